/* rtl/core/catmull_rom_curve_upsampler_top_defines.svh */
// Assertion macros for the curve upsampler checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef CATMULL_ROM_CURVE_UPSAMPLER_TOP_DEFINES_SVH
`define CATMULL_ROM_CURVE_UPSAMPLER_TOP_DEFINES_SVH

// Property that must hold at every edge outside reset
`define CRU_ASSERT_HOLD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define CRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cru_pkg.sv */
// Shared types for the Catmull-Rom curve upsampler.
// No dependencies; used by the top level and the segment engine.
`default_nettype none

package cru_pkg;

  // Curve point, signed Q.12, range -1.0 .. +1.0
  localparam int PT_W = 14;
  typedef logic signed [PT_W-1:0] point_t;

  // One segment job handed from the sample window to the engine
  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
    point_t p3;
    logic   run_last;    // last segment caused by this sample
    logic   frame_last;  // last segment of the frame
  } job_t;

endpackage

`default_nettype wire

/* rtl/core/catmull_rom_curve_upsampler_top.sv */
// Catmull-Rom curve upsampler, top level: config registers, input register,
// sample window and job stage. Depends on cru_pkg and cru_seg_engine.
//
// Usage:
//   in_*  : one spectrum magnitude per beat, in_tlast marks the frame's last.
//   out_* : one sub-segment per beat; 8 beats per segment, sub_step 0..7.
//           out_tuser flags the last beat caused by a sample, out_tlast the
//           last beat of the frame.
//   cfg_* : APB-style registers, height_scale at 0x0, bar_width at 0x4.
//           Write only while the block is idle.
// Pipeline: the beat that completes a segment passes the input register,
//   job stage, segment registers and output register. The engine emits
//   one sub-step per cycle unless out_tready is low; a frame's last sample
//   can yield two segments; a sample yielding none does not hold the input.
// Reset: empties all stages and starts a new frame; registers return to
//   height_scale 256, bar_width 8.
// Stall: a held out_tready freezes the output register and the engine; the
//   input register and job stage still take one more sample, then in_tready
//   drops.
`default_nettype none

module catmull_rom_curve_upsampler_top #(
  parameter int MAX_BARS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] magnitude
  input  logic        in_tlast,     // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,    // [11:0] segment, [14:12] sub_step, [30:15] x_start,
                                    // [46:31] h_start, [62:47] x_end, [78:63] h_end, [79] 0
  output logic        out_tuser,    // [0] run_last
  output logic        out_tlast,    // frame_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cru_pkg::*;

  localparam int SEG_W = $clog2(MAX_BARS);
  localparam int K_W   = $clog2(MAX_BARS + 1);
  localparam logic [K_W-1:0]   K_MAX    = K_W'(MAX_BARS);
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(MAX_BARS - 1);
  localparam logic REG_HEIGHT_SCALE = 1'b0;
  localparam logic REG_BAR_WIDTH    = 1'b1;

  logic [15:0]      height_scale_r;
  logic [13:0]      bar_width_r;
  logic             cfg_wr;

  logic             s1_v_r, s1_v_nxt;
  logic [15:0]      s1_mag_r;
  logic             s1_last_r;
  logic             in_acc, s1_go;

  logic [31:0]      prod;
  logic [23:0]      prod_sh;
  logic signed [14:0] p_ofs;
  point_t           p_w;

  point_t           old_r, mid_r, new_r;
  logic [K_W-1:0]   k_r;

  point_t           jw0_r, jw1_r, jw2_r, jw3_r;
  logic             pend0_r, pend1_r, jlast_r;
  logic [SEG_W-1:0] seg0_r, seg1_r;
  logic             j_v, j_rdy, j_iss, e_rdy;
  job_t             job;
  logic [SEG_W-1:0] job_seg;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_scale_r <= 16'd256;
      bar_width_r    <= 14'd8;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_HEIGHT_SCALE: height_scale_r <= cfg_pwdata[15:0];
        REG_BAR_WIDTH:    bar_width_r    <= cfg_pwdata[13:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_HEIGHT_SCALE: cfg_prdata = {16'b0, height_scale_r};
      REG_BAR_WIDTH:    cfg_prdata = {18'b0, bar_width_r};
    endcase
  end

  // input register, refilled in the cycle it hands over
  assign in_tready = !s1_v_r || j_rdy;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_go     = s1_v_r && j_rdy;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) s1_v_nxt = 1'b1;
    else if (s1_go) s1_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mag_r  <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // scale, clamp to 2.0, drop by 1.0
  always_comb begin
    prod    = {16'b0, s1_mag_r} * {16'b0, height_scale_r};
    prod_sh = prod[31:8];
    p_ofs   = $signed({1'b0, prod_sh[13:0]}) - 15'sd4096;
    p_w     = (prod_sh > 24'd8192) ? 14'sd4096 : p_ofs[13:0];
  end

  // job stage: up to two segments per sample, oldest first
  assign j_v   = pend0_r || pend1_r;
  assign j_iss = j_v && e_rdy;
  assign j_rdy = !j_v || (j_iss && (pend0_r ^ pend1_r));

  always_comb begin
    job.p0         = pend0_r ? jw0_r : jw1_r;
    job.p1         = pend0_r ? jw1_r : jw2_r;
    job.p2         = pend0_r ? jw2_r : jw3_r;
    job.p3         = jw3_r;
    job.run_last   = !(pend0_r && pend1_r);
    job.frame_last = jlast_r && !(pend0_r && pend1_r);
    job_seg        = pend0_r ? seg0_r : seg1_r;
  end

  // sample window, frame counter and pending flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      old_r   <= '0;
      mid_r   <= '0;
      new_r   <= '0;
      k_r     <= '0;
      pend0_r <= 1'b0;
      pend1_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (s1_go) begin
        if (k_r == '0) begin
          old_r   <= p_w;
          mid_r   <= p_w;
          new_r   <= p_w;
          pend0_r <= 1'b0;
          pend1_r <= 1'b0;
        end else begin
          old_r   <= mid_r;
          mid_r   <= new_r;
          new_r   <= p_w;
          pend0_r <= (k_r >= K_W'(2));
          pend1_r <= s1_last_r;
        end
        if (s1_last_r) k_r <= '0;
        else if (k_r < K_MAX) k_r <= k_r + K_W'(1);
      end else if (j_iss) begin
        if (pend0_r) pend0_r <= 1'b0;
        else pend1_r <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      jw0_r   <= old_r;
      jw1_r   <= mid_r;
      jw2_r   <= new_r;
      jw3_r   <= p_w;
      jlast_r <= s1_last_r;
      seg0_r  <= SEG_W'(k_r - K_W'(2));
      seg1_r  <= (k_r >= K_MAX) ? SEG_LAST : SEG_W'(k_r - K_W'(1));
    end
  end

  cru_seg_engine #(
    .SEG_W (SEG_W)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_v      (j_v),
    .job_rdy    (e_rdy),
    .job        (job),
    .job_seg    (job_seg),
    .bar_width  (bar_width_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* rtl/core/cru_seg_engine.sv */
// Segment engine: spline coefficients per segment, then one sub-segment beat
// per cycle into the output register while it is not stalled. Depends on cru_pkg.
`default_nettype none

module cru_seg_engine #(
  parameter int SEG_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_v,
  output logic             job_rdy,
  input  cru_pkg::job_t    job,
  input  logic [SEG_W-1:0] job_seg,
  input  logic [13:0]      bar_width,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [79:0]      out_tdata,  // segment, sub_step, x_start, h_start, x_end, h_end, pad
  output logic             out_tuser,  // run_last
  output logic             out_tlast   // frame_last
);
  import cru_pkg::*;

  localparam int XB_W = SEG_W + 16;
  localparam logic signed [XB_W-1:0] X_ORG = XB_W'(4096);
  localparam logic [2:0] STEP_LAST = 3'd7;

  // saturate a spline numerator quotient to 16 bits
  function automatic logic [15:0] sat_h(input logic signed [27:0] v);
    logic [15:0] r;
    if (v > 28'sd32767) r = 16'h7FFF;
    else if (v < -28'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  // height at sub-step s (0..8): N / 1024 truncated toward zero
  function automatic logic [15:0] spline_h(input point_t p1,
                                           input logic signed [14:0] a,
                                           input logic signed [16:0] b,
                                           input logic signed [16:0] c,
                                           input logic [3:0] s);
    logic [6:0] s2;
    logic [9:0] s3;
    logic signed [27:0] p1x, ax, bx, cx, sx, s2x, s3x, n, q;
    s2  = {3'b000, s} * {3'b000, s};
    s3  = {3'b000, s2} * {6'b000000, s};
    p1x = p1;
    ax  = a;
    bx  = b;
    cx  = c;
    sx  = $signed({24'b0, s});
    s2x = $signed({21'b0, s2});
    s3x = $signed({18'b0, s3});
    n   = (p1x <<< 10) + ((ax * sx) <<< 6) + ((bx * s2x) <<< 3) + (cx * s3x);
    q   = n[27] ? ((n + 28'sd1023) >>> 10) : (n >>> 10);
    return sat_h(q);
  endfunction

  // x at sub-step s: base + (bar_width * s) >> 3, saturated
  function automatic logic [15:0] x_at(input logic signed [XB_W-1:0] base,
                                       input logic [13:0] bw,
                                       input logic [3:0] s);
    logic [17:0] m;
    logic signed [XB_W-1:0] v;
    logic [15:0] r;
    m = {4'b0000, bw} * {14'b0, s};
    v = base + $signed(XB_W'(m[17:3]));
    if (v > $signed(XB_W'(32767))) r = 16'h7FFF;
    else if (v < -$signed(XB_W'(32768))) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  logic                   e_v_r, e_v_nxt;
  logic [2:0]             s_r;
  logic signed [14:0]     ca_r;
  logic signed [16:0]     cb_r, cc_r;
  point_t                 cp1_r;
  logic signed [XB_W-1:0] base_r;
  logic [11:0]            seg_r;
  logic                   rl_r, fl_r;
  logic                   out_v_r, out_v_nxt;
  logic [79:0]            out_data_r;
  logic                   out_user_r, out_last_r;

  logic                   o_ld, e_adv, e_done, e_load;
  logic signed [17:0]     q0, q1, q2, q3, ca_w, cb_w, cc_w;
  logic [SEG_W+13:0]      seg_prod;
  logic signed [XB_W-1:0] base_w;
  logic [3:0]             s_a, s_b;
  logic [15:0]            h_a, h_b, x_a, x_b;

  // handshake between job source, engine and output register
  assign o_ld    = !out_v_r || out_tready;
  assign e_adv   = e_v_r && o_ld;
  assign e_done  = e_adv && (s_r == STEP_LAST);
  assign job_rdy = !e_v_r || e_done;
  assign e_load  = job_v && job_rdy;

  // coefficients and x base of a new segment
  always_comb begin
    q0       = job.p0;
    q1       = job.p1;
    q2       = job.p2;
    q3       = job.p3;
    ca_w     = q2 - q0;
    cb_w     = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    cc_w     = q1 + (q1 <<< 1) - q0 - q2 - (q2 <<< 1) + q3;
    seg_prod = {14'b0, job_seg} * {{SEG_W{1'b0}}, bar_width};
    base_w   = $signed({2'b00, seg_prod}) - X_ORG;
  end

  // both endpoints of the current sub-segment
  always_comb begin
    s_a = {1'b0, s_r};
    s_b = {1'b0, s_r} + 4'd1;
    h_a = spline_h(cp1_r, ca_r, cb_r, cc_r, s_a);
    h_b = spline_h(cp1_r, ca_r, cb_r, cc_r, s_b);
    x_a = x_at(base_r, bar_width, s_a);
    x_b = x_at(base_r, bar_width, s_b);
  end

  // valid flags
  always_comb begin
    e_v_nxt = e_v_r;
    if (e_load) e_v_nxt = 1'b1;
    else if (e_done) e_v_nxt = 1'b0;
    out_v_nxt = o_ld ? e_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      e_v_r   <= e_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // segment registers and sub-step counter
  always_ff @(posedge clk) begin
    if (e_load) begin
      ca_r   <= ca_w[14:0];
      cb_r   <= cb_w[16:0];
      cc_r   <= cc_w[16:0];
      cp1_r  <= job.p1;
      base_r <= base_w;
      seg_r  <= 12'(job_seg);
      rl_r   <= job.run_last;
      fl_r   <= job.frame_last;
      s_r    <= 3'd0;
    end else if (e_adv) begin
      s_r <= s_r + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (e_adv) begin
      out_data_r <= {1'b0, h_b, x_b, h_a, x_a, s_r, seg_r};
      out_user_r <= rl_r && (s_r == STEP_LAST);
      out_last_r <= fl_r && (s_r == STEP_LAST);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/cru_checker.sv */
// Port-level checks on the curve upsampler's result channel, bound to the top.
// Depends on catmull_rom_curve_upsampler_top_defines.svh.
`default_nettype none
`include "catmull_rom_curve_upsampler_top_defines.svh"

module cru_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // a stalled beat keeps its content
  `CRU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result beat changed while stalled")

  // sub-steps of a segment follow back to back
  `CRU_ASSERT_NEXT(a_step_seq, out_tvalid && out_tready && (out_tdata[14:12] != 3'd7), out_tvalid && (out_tdata[14:12] == $past(out_tdata[14:12]) + 3'd1) && (out_tdata[11:0] == $past(out_tdata[11:0])), "sub-step sequence broken")

  // the curve is continuous between adjacent sub-segments
  `CRU_ASSERT_NEXT(a_continuity, out_tvalid && out_tready && (out_tdata[14:12] != 3'd7), (out_tdata[30:15] == $past(out_tdata[62:47])) && (out_tdata[46:31] == $past(out_tdata[78:63])), "sub-segment endpoints do not meet")

  // run and frame markers only on the last sub-step, frame end implies run end
  `CRU_ASSERT_HOLD(a_markers, !out_tvalid || ((!out_tuser || (out_tdata[14:12] == 3'd7)) && (!out_tlast || out_tuser)), "end marker on wrong beat")

endmodule

bind catmull_rom_curve_upsampler_top cru_checker u_cru_checker (.*);

`default_nettype wire

/* bench/tb_catmull_rom_curve_upsampler_top.sv */
// Self-checking bench for the Catmull-Rom curve upsampler top level.
// Needs cru_pkg and the RTL. Checks every sub-segment beat against a local
// spline predictor, under random idling on both streams and several settings.
`timescale 1ns / 100ps

module tb_catmull_rom_curve_upsampler_top;
  import cru_pkg::*;

  localparam int  MAX_BARS     = 4096;
  localparam int  LIMIT_CYCLES = 600000;
  localparam int  DRAIN_CYCLES = 24;
  localparam int  MAX_REPORTS  = 40;
  localparam int  RESET_CYCLES = 9;

  // Register byte addresses
  localparam logic [2:0] REG_HEIGHT_SCALE = 3'h0;
  localparam logic [2:0] REG_BAR_WIDTH    = 3'h4;

  typedef struct packed {
    logic [15:0] mag;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [11:0]        segment;
    logic [2:0]         sub_step;
    logic signed [15:0] x_start;
    logic signed [15:0] h_start;
    logic signed [15:0] x_end;
    logic signed [15:0] h_end;
    logic               run_last;
    logic               frame_last;
  } subseg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  catmull_rom_curve_upsampler_top #(.MAX_BARS(MAX_BARS)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sample_t pending_samples[$];
  subseg_t expected_subsegs[$];
  sample_t beat_on_bus;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      err_count = 0;
  int      cycle_count = 0;

  // Predictor state and its copy of the registers
  int unsigned gain_q8 = 256;
  int unsigned seg_width = 8;
  point_t      pt_oldest = '0;
  point_t      pt_middle = '0;
  point_t      pt_newest = '0;
  int unsigned frame_samples = 0;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic point_t scale_magnitude(logic [15:0] mag);
    longint prod;
    prod = (longint'(mag) * longint'(gain_q8)) >>> 8;
    if (prod > 8192) prod = 8192;
    return point_t'(prod - 4096);
  endfunction

  // Spline height at t = s/8, numerator over 1024 truncated toward zero
  function automatic longint curve_height(longint p0, longint p1, longint p2, longint p3,
                                          longint s);
    longint a, b, c, n;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    n = 1024 * p1 + 64 * a * s + 8 * b * s * s + c * s * s * s;
    return sat16(n / 1024);
  endfunction

  function automatic longint x_coord(int unsigned seg, longint s);
    longint base;
    base = -4096 + longint'(seg) * longint'(seg_width);
    return sat16(base + ((longint'(seg_width) * s) >>> 3));
  endfunction

  function automatic void push_segment(int unsigned seg, point_t p0, point_t p1,
                                       point_t p2, point_t p3);
    subseg_t r;
    for (int s = 0; s < 8; s++) begin
      r.segment    = seg[11:0];
      r.sub_step   = s[2:0];
      r.x_start    = 16'(x_coord(seg, s));
      r.h_start    = 16'(curve_height(p0, p1, p2, p3, s));
      r.x_end      = 16'(x_coord(seg, s + 1));
      r.h_end      = 16'(curve_height(p0, p1, p2, p3, s + 1));
      r.run_last   = 1'b0;
      r.frame_last = 1'b0;
      expected_subsegs = {expected_subsegs, r};
    end
  endfunction

  // Advance the sample window by one accepted beat and queue its sub-segments
  function automatic void predict_sample(sample_t smp);
    point_t      p;
    int unsigned k;
    int          q_before;
    p = scale_magnitude(smp.mag);
    k = frame_samples;
    q_before = expected_subsegs.size();
    if (k == 0) begin
      pt_oldest = p;
      pt_middle = p;
      pt_newest = p;
    end else begin
      if (k >= 2) push_segment(k - 2, pt_oldest, pt_middle, pt_newest, p);
      pt_oldest = pt_middle;
      pt_middle = pt_newest;
      pt_newest = p;
      if (smp.last)
        push_segment((k >= MAX_BARS) ? MAX_BARS - 1 : k - 1,
                     pt_oldest, pt_middle, pt_newest, pt_newest);
    end
    if (expected_subsegs.size() > q_before) begin
      expected_subsegs[expected_subsegs.size() - 1].run_last   = 1'b1;
      expected_subsegs[expected_subsegs.size() - 1].frame_last = smp.last;
    end
    if (smp.last) frame_samples = 0;
    else if (frame_samples < MAX_BARS) frame_samples++;
  endfunction

  // Input driver: holds a beat until taken, then fetches the next
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_sample(beat_on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          beat_on_bus = pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= beat_on_bus.mag;
          in_tlast  <= beat_on_bus.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (err_count < MAX_REPORTS)
        $display("%0t: %s expected %h, actual %h", $realtime, name, want, got);
      err_count++;
    end
  endtask

  // Output monitor with random back-pressure
  always @(posedge clk) begin
    subseg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_subsegs.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual %h user %b last %b",
                   $realtime, out_tdata, out_tuser, out_tlast);
        err_count++;
      end else begin
        want = expected_subsegs.pop_front();
        check_field("segment",    16'(want.segment),    16'(out_tdata[11:0]));
        check_field("sub_step",   16'(want.sub_step),   16'(out_tdata[14:12]));
        check_field("x_start",    want.x_start,         out_tdata[30:15]);
        check_field("h_start",    want.h_start,         out_tdata[46:31]);
        check_field("x_end",      want.x_end,           out_tdata[62:47]);
        check_field("h_end",      want.h_end,           out_tdata[78:63]);
        check_field("run_last",   16'(want.run_last),   16'(out_tuser));
        check_field("frame_last", 16'(want.frame_last), 16'(out_tlast));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == REG_HEIGHT_SCALE) gain_q8 = data[15:0];
    else if (addr == REG_BAR_WIDTH) seg_width = data[13:0];
  endtask

  task automatic set_config(input int unsigned gain, input int unsigned width);
    reg_write(REG_HEIGHT_SCALE, gain);
    reg_write(REG_BAR_WIDTH, width);
  endtask

  function automatic void push_sample(logic [15:0] mag, logic last);
    sample_t smp;
    smp.mag  = mag;
    smp.last = last;
    pending_samples = {pending_samples, smp};
  endfunction

  // Magnitudes biased towards the unclamped range, with extremes and raw noise
  function automatic logic [15:0] rand_magnitude();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 16'($urandom_range(0, 9000));
    if (pick < 75) return 16'($urandom);
    if (pick < 87) return 16'h0000;
    return 16'hFFFF;
  endfunction

  // Whole random frames until about n beats are queued
  task automatic push_random_frames(input int n);
    int queued;
    int flen;
    int pick;
    queued = 0;
    while (queued < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) flen = 1;
      else if (pick < 85) flen = $urandom_range(2, 10);
      else flen = $urandom_range(11, 40);
      for (int i = 0; i < flen; i++) push_sample(rand_magnitude(), i == flen - 1);
      queued += flen;
    end
  endtask

  // Wait until every beat is taken and answered, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_subsegs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, slow sender against a very slow receiver
    send_idle_pct = 28;
    recv_idle_pct = 87;
    // single-sample frame: silent
    push_sample(16'h0000, 1'b1);
    // two samples: segment 0 with its last point repeated
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    // clamp edge and just above the floor
    push_sample(16'h2000, 1'b0);
    push_sample(16'h1000, 1'b0);
    push_sample(16'h0001, 1'b1);
    // alternating extremes, final segment follows the one two back
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h3039, 1'b1);
    push_random_frames(60);
    wait_drained();

    // Largest gain and width: heights clamp, x saturates; roles swapped
    send_idle_pct = 87;
    recv_idle_pct = 28;
    set_config(16'hFFFF, 14'h3FFF);
    push_random_frames(60);
    wait_drained();

    // No idling from here on; zero gain and zero width
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(0, 0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h1234, 1'b0);
    push_sample(16'h0000, 1'b1);
    wait_drained();

    // Random settings
    set_config($urandom_range(0, 65535), $urandom_range(1, 8192));
    push_random_frames(70);
    wait_drained();

    if (err_count == 0 && expected_subsegs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (expected_subsegs.size() != 0)
        $display("%0t: %0d sub-segments expected, never seen", $realtime,
                 expected_subsegs.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
